FILE: rtl/core/mbm_pkg.sv
// Shared widths, codes and constants of the bipartite matching block.
`timescale 1ns / 1ps
package mbm_pkg;
	localparam int VTX_W       = 6;
	localparam int CNT_W       = 6;
	localparam int RESULT_CAP  = 32;
	localparam int DEF_MAX_U   = 32;
	localparam int DEF_MAX_V   = 32;
	// layer distances stay below the left size plus two, so seven bits hold them
	localparam int DIST_W      = 7;
	localparam logic [DIST_W-1:0] DIST_INF = '1;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_U_COUNT = 1'b0,
		CFG_V_COUNT = 1'b1
	} cfg_reg_t;
endpackage

FILE: rtl/core/mbm_if.sv
// Stream interfaces for edge items and matching results.
`timescale 1ns / 1ps
interface mbm_edge_if;
	logic                     valid;
	logic                     ready;
	logic [mbm_pkg::VTX_W-1:0] left_vertex;
	logic [mbm_pkg::VTX_W-1:0] right_vertex;
	logic                     has_edge;
	logic                     last;
	modport source (output valid, left_vertex, right_vertex, has_edge, last, input ready);
	modport sink (input valid, left_vertex, right_vertex, has_edge, last, output ready);
endinterface

interface mbm_result_if;
	logic                      valid;
	logic                      ready;
	logic [mbm_pkg::VTX_W-1:0] left_index;
	logic [mbm_pkg::VTX_W-1:0] partner;
	logic [mbm_pkg::CNT_W-1:0] matching_size;
	logic                      dropped;
	logic                      last_result;
	modport source (output valid, left_index, partner, matching_size, dropped, last_result,
		input ready);
	modport sink (input valid, left_index, partner, matching_size, dropped, last_result,
		output ready);
endinterface

FILE: rtl/core/mbm_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps
module mbm_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/core/max_bipartite_matching.sv
// Top level of the Hopcroft-Karp maximum bipartite matching block.
// Usage:
//   Write u_count and v_count through the cfg port while the block is idle.
//   Stream edges on 'edges'; each transfer appends (left_vertex, right_vertex)
//   to the list of its left vertex. Bad or overflowing edges are
//   dropped and flagged. A transfer with last set closes the graph.
//   The block then runs the matching: each layering pass visits every left
//   vertex, then every queued vertex and the list entries it scans; each depth
//   search tries list entries and pushes a stack frame per step down.
//   The single read port of the adjacency RAM sets their pace.
//   'edges' is not ready during matching and emission.
//   Results come out on 'results', one per left vertex 1..u_count, capped at 32 (or a single
//   one with left_index 0 when u_count is zero), one per cycle unless the
//   receiver stalls; a stall holds the result register and the emission.
//   After the final result is loaded the lists and partners are cleared at
//   once and the block takes edges again.
//   Reset clears registers, lists and partners; no clearing pass is needed.
`timescale 1ns / 1ps
module max_bipartite_matching #(
	parameter int MAX_U = mbm_pkg::DEF_MAX_U,
	parameter int MAX_V = mbm_pkg::DEF_MAX_V
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [mbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbm_pkg::CFG_DATA_W-1:0] cfg_data,
	mbm_edge_if.sink                       edges,
	mbm_result_if.source                   results
);
	import mbm_pkg::*;

	localparam int U_ROWS = (MAX_U < RESULT_CAP) ? MAX_U : RESULT_CAP;
	localparam int UIW    = (U_ROWS > 1) ? $clog2(U_ROWS) : 1;
	localparam int VIW    = (MAX_V > 1) ? $clog2(MAX_V) : 1;
	localparam int LW     = $clog2(MAX_V + 1);
	localparam int AAW    = UIW + VIW;
	localparam int RP_MAX = (MAX_V < 63) ? MAX_V : 63;
	localparam int RPD    = RP_MAX + 1;
	localparam int RPW    = $clog2(RPD);
	localparam int QD     = U_ROWS + 2;
	localparam int QAW    = $clog2(QD);
	localparam int QW     = $clog2(QD + 1);
	localparam int TW     = (U_ROWS > 1) ? $clog2(U_ROWS) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_BINIT, S_BPOP, S_BCUR, S_BEDGE, S_BV, S_BW,
		S_AROOT, S_AFETCH, S_AV, S_AW, S_AWALK, S_EMIT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  u_count_q, v_count_q;
	logic [CNT_W-1:0]  nu, nv;
	logic [VTX_W-1:0]  ucnt_q, cur_q, v_q;
	logic [LW-1:0]     idx_q;
	logic [DIST_W-1:0] cdist_q, dist0_q;
	logic [TW-1:0]     top_q;
	logic [QW-1:0]     head_q, tail_q;
	logic [CNT_W-1:0]  pair_q;
	logic              drop_q;

	logic [LW-1:0]     len_q      [U_ROWS];
	logic [VTX_W-1:0]  lp_q       [U_ROWS];
	logic [DIST_W-1:0] dist_q     [U_ROWS];
	logic              rp_vld_q   [RPD];
	logic [VTX_W-1:0]  stk_node_q [U_ROWS];
	logic [LW-1:0]     stk_idx_q  [U_ROWS];
	logic [VTX_W-1:0]  stk_v_q    [U_ROWS];
	logic [DIST_W-1:0] stk_dist_q [U_ROWS];

	logic              ov_q, olast_q, odrop_q;
	logic [VTX_W-1:0]  oidx_q, opart_q;
	logic [CNT_W-1:0]  osize_q;

	// RAM ports
	logic              adj_we;
	logic [AAW-1:0]    adj_waddr, adj_raddr;
	logic [VTX_W-1:0]  adj_rdata;
	logic              rp_we;
	logic [RPW-1:0]    rp_waddr, rp_raddr;
	logic [VTX_W-1:0]  rp_rdata;
	logic              rp_hit_s;
	logic              q_we;
	logic [QAW-1:0]    q_waddr, q_raddr;
	logic [VTX_W-1:0]  q_wdata, q_rdata;

	logic              in_acc, edge_ok, v_ok, out_load;
	logic [VTX_W-1:0]  w, len_ra, dist_ra;
	logic [LW-1:0]     rd_len;
	logic [DIST_W-1:0] rd_dist, dist_up;
	logic [VTX_W-1:0]  rd_lp;

	assign nu = (u_count_q > CNT_W'(U_ROWS)) ? CNT_W'(U_ROWS) : u_count_q;
	assign nv = (32'(v_count_q) > MAX_V) ? CNT_W'(RP_MAX) : v_count_q;

	assign edges.ready = (state_q == S_IDLE);
	assign in_acc      = edges.valid && edges.ready;

	assign w       = rp_hit_s ? rp_rdata : '0;
	assign v_ok    = (adj_rdata != '0) && (adj_rdata <= nv);
	assign dist_up = cdist_q + DIST_W'(1);

	// one read address per small store, chosen by state
	always_comb begin
		unique case (state_q)
			S_IDLE:       len_ra = edges.left_vertex;
			S_BCUR:       len_ra = q_rdata;
			S_BW, S_AW:   len_ra = w;
			default:      len_ra = ucnt_q;
		endcase
	end
	assign dist_ra = len_ra;
	assign rd_len  = len_q[UIW'(len_ra - VTX_W'(1))];
	assign rd_dist = (dist_ra == '0) ? dist0_q : dist_q[UIW'(dist_ra - VTX_W'(1))];
	assign rd_lp   = lp_q[UIW'(ucnt_q - VTX_W'(1))];

	assign edge_ok = (edges.left_vertex != '0) && (edges.left_vertex <= nu) &&
		(edges.right_vertex != '0) && (edges.right_vertex <= nv) &&
		(32'(rd_len) < MAX_V);

	assign adj_we    = in_acc && edges.has_edge && edge_ok;
	assign adj_waddr = {UIW'(edges.left_vertex - VTX_W'(1)), VIW'(rd_len)};
	assign adj_raddr = {UIW'(cur_q - VTX_W'(1)), VIW'(idx_q - LW'(1))};

	assign rp_we    = (state_q == S_AWALK);
	assign rp_waddr = RPW'(v_q);
	assign rp_raddr = RPW'(adj_rdata);

	assign q_we    = ((state_q == S_BINIT) && (ucnt_q <= nu) && (rd_lp == '0)) ||
		((state_q == S_BW) && (w <= nu) && (rd_dist == DIST_INF));
	assign q_waddr = head_q[QAW-1:0];
	assign q_wdata = (state_q == S_BINIT) ? ucnt_q : w;
	assign q_raddr = tail_q[QAW-1:0];

	assign out_load = (state_q == S_EMIT) && (!ov_q || results.ready);

	mbm_ram #(.WIDTH(VTX_W), .DEPTH(2 ** AAW)) u_adj_ram (
		.clk, .we(adj_we), .waddr(adj_waddr), .wdata(edges.right_vertex),
		.raddr(adj_raddr), .rdata(adj_rdata)
	);

	mbm_ram #(.WIDTH(VTX_W), .DEPTH(RPD)) u_rp_ram (
		.clk, .we(rp_we), .waddr(rp_waddr), .wdata(cur_q),
		.raddr(rp_raddr), .rdata(rp_rdata)
	);

	mbm_ram #(.WIDTH(VTX_W), .DEPTH(QD)) u_queue_ram (
		.clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			u_count_q <= '0;
			v_count_q <= '0;
			ucnt_q    <= '0;
			cur_q     <= '0;
			v_q       <= '0;
			idx_q     <= '0;
			cdist_q   <= '0;
			dist0_q   <= '0;
			top_q     <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			pair_q    <= '0;
			drop_q    <= 1'b0;
			rp_hit_s  <= 1'b0;
			ov_q      <= 1'b0;
			olast_q   <= 1'b0;
			odrop_q   <= 1'b0;
			oidx_q    <= '0;
			opart_q   <= '0;
			osize_q   <= '0;
			for (int i = 0; i < U_ROWS; i++) begin
				len_q[i]      <= '0;
				lp_q[i]       <= '0;
				dist_q[i]     <= '0;
				stk_node_q[i] <= '0;
				stk_idx_q[i]  <= '0;
				stk_v_q[i]    <= '0;
				stk_dist_q[i] <= '0;
			end
			for (int i = 0; i < RPD; i++) begin
				rp_vld_q[i] <= 1'b0;
			end
		end else begin
			rp_hit_s <= rp_vld_q[rp_raddr];
			if (cfg_write) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_U_COUNT: u_count_q <= cfg_data;
					CFG_V_COUNT: v_count_q <= cfg_data;
				endcase
			end
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end
			if (q_we) begin
				head_q <= head_q + QW'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (edges.has_edge) begin
							if (edge_ok) begin
								len_q[UIW'(edges.left_vertex - VTX_W'(1))] <= rd_len + LW'(1);
							end else begin
								drop_q <= 1'b1;
							end
						end
						if (edges.last) begin
							state_q <= S_BINIT;
							ucnt_q  <= VTX_W'(1);
							dist0_q <= DIST_INF;
							head_q  <= '0;
							tail_q  <= '0;
						end
					end
				end
				S_BINIT: begin
					if (ucnt_q > nu) begin
						state_q <= S_BPOP;
					end else begin
						dist_q[UIW'(ucnt_q - VTX_W'(1))] <= (rd_lp == '0) ? '0 : DIST_INF;
						ucnt_q <= ucnt_q + VTX_W'(1);
					end
				end
				S_BPOP: begin
					if (tail_q == head_q) begin
						ucnt_q  <= VTX_W'(1);
						state_q <= (dist0_q != DIST_INF) ? S_AROOT : S_EMIT;
					end else begin
						tail_q  <= tail_q + QW'(1);
						state_q <= S_BCUR;
					end
				end
				S_BCUR: begin
					cur_q <= q_rdata;
					if (rd_dist >= dist0_q) begin
						state_q <= S_BPOP;
					end else begin
						cdist_q <= rd_dist;
						idx_q   <= rd_len;
						state_q <= S_BEDGE;
					end
				end
				S_BEDGE: begin
					if (idx_q == '0) begin
						state_q <= S_BPOP;
					end else begin
						idx_q   <= idx_q - LW'(1);
						state_q <= S_BV;
					end
				end
				S_BV: begin
					state_q <= v_ok ? S_BW : S_BEDGE;
				end
				S_BW: begin
					if ((w <= nu) && (rd_dist == DIST_INF)) begin
						if (w == '0) begin
							dist0_q <= dist_up;
						end else begin
							dist_q[UIW'(w - VTX_W'(1))] <= dist_up;
						end
					end
					state_q <= S_BEDGE;
				end
				S_AROOT: begin
					if (ucnt_q > nu) begin
						state_q <= S_BINIT;
						ucnt_q  <= VTX_W'(1);
						dist0_q <= DIST_INF;
						head_q  <= '0;
						tail_q  <= '0;
					end else if ((rd_lp != '0) || (rd_dist == DIST_INF)) begin
						ucnt_q <= ucnt_q + VTX_W'(1);
					end else begin
						cur_q   <= ucnt_q;
						idx_q   <= rd_len;
						cdist_q <= rd_dist;
						top_q   <= '0;
						state_q <= S_AFETCH;
					end
				end
				S_AFETCH: begin
					if (idx_q == '0) begin
						// dead end: retire this vertex for the rest of the pass
						dist_q[UIW'(cur_q - VTX_W'(1))] <= DIST_INF;
						if (top_q == '0) begin
							ucnt_q  <= ucnt_q + VTX_W'(1);
							state_q <= S_AROOT;
						end else begin
							cur_q   <= stk_node_q[top_q - TW'(1)];
							idx_q   <= stk_idx_q[top_q - TW'(1)];
							v_q     <= stk_v_q[top_q - TW'(1)];
							cdist_q <= stk_dist_q[top_q - TW'(1)];
							top_q   <= top_q - TW'(1);
						end
					end else begin
						idx_q   <= idx_q - LW'(1);
						state_q <= S_AV;
					end
				end
				S_AV: begin
					v_q     <= adj_rdata;
					state_q <= v_ok ? S_AW : S_AFETCH;
				end
				S_AW: begin
					if ((w > nu) || (rd_dist != dist_up)) begin
						state_q <= S_AFETCH;
					end else if (w == '0) begin
						state_q <= S_AWALK;
					end else begin
						stk_node_q[top_q] <= cur_q;
						stk_idx_q[top_q]  <= idx_q;
						stk_v_q[top_q]    <= v_q;
						stk_dist_q[top_q] <= cdist_q;
						top_q   <= top_q + TW'(1);
						cur_q   <= w;
						idx_q   <= rd_len;
						cdist_q <= dist_up;
						state_q <= S_AFETCH;
					end
				end
				S_AWALK: begin
					// flip one edge of the augmenting path per cycle, top down
					lp_q[UIW'(cur_q - VTX_W'(1))] <= v_q;
					rp_vld_q[RPW'(v_q)] <= 1'b1;
					if (top_q == '0) begin
						pair_q  <= pair_q + CNT_W'(1);
						ucnt_q  <= ucnt_q + VTX_W'(1);
						state_q <= S_AROOT;
					end else begin
						cur_q   <= stk_node_q[top_q - TW'(1)];
						idx_q   <= stk_idx_q[top_q - TW'(1)];
						v_q     <= stk_v_q[top_q - TW'(1)];
						cdist_q <= stk_dist_q[top_q - TW'(1)];
						top_q   <= top_q - TW'(1);
					end
				end
				S_EMIT: begin
					if (out_load) begin
						oidx_q  <= (nu == '0) ? '0 : ucnt_q;
						opart_q <= (nu == '0) ? '0 : rd_lp;
						osize_q <= pair_q;
						odrop_q <= drop_q;
						olast_q <= (nu == '0) || (ucnt_q == nu);
						if ((nu == '0) || (ucnt_q == nu)) begin
							// result captured: drop the graph for the next run
							for (int i = 0; i < U_ROWS; i++) begin
								len_q[i] <= '0;
								lp_q[i]  <= '0;
							end
							for (int i = 0; i < RPD; i++) begin
								rp_vld_q[i] <= 1'b0;
							end
							pair_q  <= '0;
							drop_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							ucnt_q <= ucnt_q + VTX_W'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign results.valid         = ov_q;
	assign results.left_index    = oidx_q;
	assign results.partner       = opart_q;
	assign results.matching_size = osize_q;
	assign results.dropped       = odrop_q;
	assign results.last_result   = olast_q;

`ifndef SYNTH
	a_pairs_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pair_q <= CNT_W'(U_ROWS))
		else $error("matching size exceeds left side");
	a_queue_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (tail_q == head_q))
		else $error("emission started with vertices still queued");
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.last_result) |->
		((results.left_index == '0) || (results.left_index == nu)))
		else $error("final result does not report the last left vertex");
`endif
endmodule

FILE: tb/tb_max_bipartite_matching.sv
// Self-checking testbench of the Hopcroft-Karp bipartite matching block.
`timescale 1ns / 1ps
module tb_max_bipartite_matching;
	import mbm_pkg::*;

	localparam int LIST_CAP   = 32;
	localparam int LEFT_CAP   = 32;
	localparam int FAR        = 32767;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_LEN   = 2000;

	typedef struct packed {
		logic [VTX_W-1:0] left_index;
		logic [VTX_W-1:0] partner;
		logic [CNT_W-1:0] matching_size;
		logic             dropped;
		logic             last_result;
	} match_res_t;

	class match_board;
		int        u_size, v_size;
		int        adj[LEFT_CAP+1][LIST_CAP];
		int        adj_len[LEFT_CAP+1];
		int        lmate[LEFT_CAP+1];
		int        rmate[LIST_CAP+1];
		int        layer[LEFT_CAP+1];
		int        pairs;
		bit        any_drop;
		int        errors;
		int        results_seen;
		match_res_t pending_q[$];

		function void clear_graph();
			for (int i = 0; i <= LEFT_CAP; i++) begin
				adj_len[i] = 0;
				lmate[i] = 0;
				rmate[i] = 0;
			end
			pairs = 0;
			any_drop = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, int val);
			if (idx == CFG_U_COUNT) u_size = val;
			else v_size = val;
		endfunction

		function bit layer_graph(int nu, int nv);
			int q[$];
			int cur, v, w;
			layer[0] = FAR;
			for (int u = 1; u <= nu; u++) begin
				if (lmate[u] == 0) begin
					layer[u] = 0;
					q.push_back(u);
				end else layer[u] = FAR;
			end
			while (q.size() > 0) begin
				cur = q.pop_front();
				if (layer[cur] >= layer[0]) continue;
				for (int i = adj_len[cur]; i > 0; i--) begin
					v = adj[cur][i-1];
					if (v == 0 || v > nv) continue;
					w = rmate[v];
					if (w > nu) continue;
					if (layer[w] == FAR) begin
						layer[w] = layer[cur] + 1;
						q.push_back(w);
					end
				end
			end
			return layer[0] != FAR;
		endfunction

		function bit augment(int root, int nu, int nv);
			int node[LEFT_CAP+1];
			int pos[LEFT_CAP+1];
			int top, u, v, w, a, b;
			top = 0;
			if (layer[root] == FAR) return 0;
			node[0] = root;
			pos[0] = adj_len[root];
			forever begin
				u = node[top];
				if (pos[top] == 0) begin
					layer[u] = FAR;
					if (top == 0) return 0;
					top--;
					continue;
				end
				pos[top]--;
				v = adj[u][pos[top]];
				if (v == 0 || v > nv) continue;
				w = rmate[v];
				if (w > nu) continue;
				if (layer[w] != layer[u] + 1) continue;
				if (w == 0) begin
					for (int k = top; k >= 0; k--) begin
						a = node[k];
						b = adj[a][pos[k]];
						rmate[b] = a;
						lmate[a] = b;
					end
					return 1;
				end
				if (top + 1 >= LEFT_CAP + 1) continue;
				top++;
				node[top] = w;
				pos[top] = adj_len[w];
			end
		endfunction

		function void note_edge(int l, int r, bit has, bit fin);
			int nu, nv;
			match_res_t res;
			nu = (u_size > LEFT_CAP) ? LEFT_CAP : u_size;
			nv = (v_size > LIST_CAP) ? LIST_CAP : v_size;
			if (has) begin
				if (l == 0 || l > nu || r == 0 || r > nv || adj_len[l] >= LIST_CAP)
					any_drop = 1;
				else begin
					adj[l][adj_len[l]] = r;
					adj_len[l]++;
				end
			end
			if (!fin) return;
			while (layer_graph(nu, nv))
				for (int u = 1; u <= nu; u++)
					if (lmate[u] == 0 && augment(u, nu, nv)) pairs++;
			if (nu == 0) begin
				res = '{6'd0, 6'd0, pairs[5:0], any_drop, 1'b1};
				pending_q.push_back(res);
			end else begin
				for (int u = 1; u <= nu; u++) begin
					res = '{u[5:0], lmate[u][5:0], pairs[5:0], any_drop, u == nu};
					pending_q.push_back(res);
				end
			end
			clear_graph();
		endfunction

		function void check_result(match_res_t got);
			match_res_t want;
			results_seen++;
			if (pending_q.size() == 0) begin
				$error("unexpected result left_index=%0d", got.left_index);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			if (got.left_index != want.left_index) begin
				$error("left_index exp %0d got %0d", want.left_index, got.left_index);
				errors++;
			end
			if (got.partner != want.partner) begin
				$error("partner exp %0d got %0d", want.partner, got.partner);
				errors++;
			end
			if (got.matching_size != want.matching_size) begin
				$error("matching_size exp %0d got %0d", want.matching_size, got.matching_size);
				errors++;
			end
			if (got.dropped != want.dropped) begin
				$error("dropped exp %0d got %0d", want.dropped, got.dropped);
				errors++;
			end
			if (got.last_result != want.last_result) begin
				$error("last_result exp %0d got %0d", want.last_result, got.last_result);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mbm_edge_if   edges ();
	mbm_result_if results ();

	max_bipartite_matching DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.edges     (edges.sink),
		.results   (results.source)
	);

	match_board board;
	int  idle_cycles;
	int  items_sent;
	bit  hold_request;
	bit  no_gaps;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// note transfers and check results at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (edges.valid && edges.ready)
				board.note_edge(edges.left_vertex, edges.right_vertex,
					edges.has_edge, edges.last);
			if (results.valid && results.ready)
				board.check_result('{results.left_index, results.partner,
					results.matching_size, results.dropped, results.last_result});
			if ((edges.valid && edges.ready) || (results.valid && results.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		int held;
		results.ready = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				held = 0;
				results.ready <= 1'b0;
				while (held < HOLD_LEN) begin
					@(posedge clk);
					held++;
				end
				hold_request = 0;
			end
			if (stall > 0) begin
				stall--;
				results.ready <= 1'b0;
			end else begin
				results.ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, int val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		board.set_reg(idx, val);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// wait for the block to drain, then let it settle
	task automatic drain();
		edges.valid <= 1'b0;
		@(posedge clk);
		while (board.pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_edge(int l, int r, bit has, bit fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			edges.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		edges.valid        <= 1'b1;
		edges.left_vertex  <= l[VTX_W-1:0];
		edges.right_vertex <= r[VTX_W-1:0];
		edges.has_edge     <= has;
		edges.last         <= fin;
		@(posedge clk);
		while (!edges.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic run_graph(int nu, int nv, int n_edges, bit overflow);
		int l, r;
		drain();
		write_reg(CFG_U_COUNT, nu);
		write_reg(CFG_V_COUNT, nv);
		no_gaps = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n_edges; i++) begin
			if (overflow) send_edge(1, (i % 2) + 1, 1'b1, 1'b0);
			else if ($urandom_range(0, 99) < 85) begin
				l = (nu == 0) ? 0 : $urandom_range(1, (nu > 32) ? 32 : nu);
				r = (nv == 0) ? 0 : $urandom_range(1, (nv > 32) ? 32 : nv);
				send_edge(l, r, 1'b1, 1'b0);
			end else
				send_edge($urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 1), 1'b0);
		end
		if ($urandom_range(0, 1))
			send_edge($urandom_range(0, 63), $urandom_range(0, 63), 1'b1, 1'b1);
		else
			send_edge(0, 0, 1'b0, 1'b1);
		no_gaps = 0;
	endtask

	initial begin
		int nu, nv;
		board = new();
		board.u_size = 0;
		board.v_size = 0;
		board.clear_graph();
		board.errors = 0;
		board.results_seen = 0;
		idle_cycles = 0;
		items_sent = 0;
		hold_request = 0;
		no_gaps = 0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_U_COUNT;
		cfg_data = '0;
		edges.valid = 1'b0;
		edges.left_vertex = '0;
		edges.right_vertex = '0;
		edges.has_edge = 1'b0;
		edges.last = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty left side: one result only
		send_edge(0, 0, 1'b0, 1'b1);
		drain();
		write_reg(CFG_U_COUNT, 32);
		write_reg(CFG_V_COUNT, 32);
		send_edge(1, 1, 1'b1, 1'b0);
		send_edge(32, 32, 1'b1, 1'b0);
		send_edge(0, 5, 1'b1, 1'b0);
		send_edge(33, 1, 1'b1, 1'b0);
		send_edge(5, 0, 1'b1, 1'b0);
		send_edge(63, 63, 1'b1, 1'b0);
		send_edge(7, 7, 1'b0, 1'b0);
		send_edge(2, 1, 1'b1, 1'b1);
		drain();
		// shrink sizes after loading: edges above the new sizes go unused
		write_reg(CFG_U_COUNT, 3);
		write_reg(CFG_V_COUNT, 3);
		send_edge(3, 3, 1'b1, 1'b0);
		send_edge(2, 3, 1'b1, 1'b0);
		send_edge(1, 2, 1'b1, 1'b0);
		send_edge(3, 1, 1'b1, 1'b0);
		edges.valid <= 1'b0;
		repeat (8) @(posedge clk);
		write_reg(CFG_U_COUNT, 2);
		write_reg(CFG_V_COUNT, 2);
		send_edge(1, 1, 1'b1, 1'b1);

		// full list on one left vertex
		run_graph(2, 2, 34, 1'b1);

		// sender keeps offering while results are held back
		drain();
		hold_request = 1;
		run_graph(32, 32, 6, 1'b0);
		send_edge(3, 4, 1'b1, 1'b0);
		send_edge(4, 3, 1'b1, 1'b1);
		send_edge(5, 6, 1'b1, 1'b0);
		send_edge(6, 5, 1'b1, 1'b1);
		run_graph(4, 4, 6, 1'b0);

		while (items_sent < 100) begin
			case ($urandom_range(0, 5))
				0: nu = 0;
				1: nu = $urandom_range(33, 63);
				2: nu = 32;
				default: nu = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 4))
				0: nv = $urandom_range(0, 63);
				1: nv = 32;
				default: nv = $urandom_range(1, 8);
			endcase
			run_graph(nu, nv, $urandom_range(0, 12), 1'b0);
		end
		drain();
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

FILE: filelist.f
rtl/core/mbm_pkg.sv
rtl/core/mbm_if.sv
rtl/core/mbm_ram.sv
rtl/core/max_bipartite_matching.sv
tb/tb_max_bipartite_matching.sv
